[rtl/kwrm_pkg.sv]
// ----------------------------------------------------------------------------
// kwrm_pkg
// Types and constants shared by the keyed window rate meter.
// ----------------------------------------------------------------------------
package kwrm_pkg;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] CSR_IDLE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_PERIOD     = 2'd1;
   localparam logic [1:0] CSR_MAX_TRACK  = 2'd2;

   localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;
   localparam logic [31:0] MS_PER_SEC    = 32'd1000;
   localparam logic [31:0] IDLE_RESET    = 32'd5000;
   localparam logic [31:0] PERIOD_RESET  = 32'd1000;
   localparam logic [31:0] TRACK_RESET   = 32'd10000;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key;
      logic [31:0] amount;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [31:0] rate;
      logic        found;
      logic        dropped;
      logic        active;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_CLEAR,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DIV,
      ST_DIV_WAIT,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

[rtl/kwrm_ram.sv]
// ----------------------------------------------------------------------------
// kwrm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module kwrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/kwrm_div.sv]
// ----------------------------------------------------------------------------
// kwrm_div
// Restoring divider, one quotient bit per cycle, 32-bit quotient result.
// ----------------------------------------------------------------------------
module kwrm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  kwrm_pkg::div_req_type div_req,
   output kwrm_pkg::div_rsp_type div_rsp
);
   import kwrm_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   // step one dividend bit into the remainder
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]} - {1'b0, dvs_ff};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[32]) begin
            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[31:0];
endmodule

[rtl/keyed_window_rate_meter.sv]
// ----------------------------------------------------------------------------
// keyed_window_rate_meter
// Per-key sliding-window rate meter with a sequenced bucket memory.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and rsp_valid pulses
// for one cycle with the result in the first cycle that busy is low again;
// the receiver cannot stall it. A query walks the key table one entry per
// cycle. An add walks it likewise, then adds to a present key's newest
// bucket, zeroes a new key's window word by word with the amount in the
// newest slot, or is dropped when no entry is free. An inactive tick or an
// unknown command goes straight to the response. A tick that clears walks
// the bucket memory one word per cycle. A period tick skips empty entries
// and, for each valid entry, does WINDOW reads to sum, runs the 64-step
// shared divider and waits for its done, then does WINDOW-1 read/write
// pairs to shift.
module keyed_window_rate_meter #(
   parameter int ENTRIES = 16,
   parameter int WINDOW  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  kwrm_pkg::req_type req_data,
   output logic              rsp_valid,
   output kwrm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import kwrm_pkg::*;

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int DEPTH = ENTRIES * WINDOW;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DEPTH_P = 1 << AW;

   // configuration
   logic [31:0] idle_limit_ff, period_ff, max_track_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_RESET;
         period_ff     <= PERIOD_RESET;
         max_track_ff  <= TRACK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDLE_LIMIT: idle_limit_ff <= csr_wdata;
            CSR_PERIOD:     period_ff     <= csr_wdata;
            CSR_MAX_TRACK:  max_track_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? SAT32 : s[31:0];
   endfunction

   // state
   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] key_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0] rate_ff [ENTRIES];
   logic        active_ff, active_in;
   logic [31:0] idle_t_ff, idle_t_in, per_t_ff, per_t_in, trk_t_ff, trk_t_in;
   logic [EW:0] idx_ff, idx_in;
   logic        hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [EW-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [WW:0] w_ff, w_in;
   logic [AW:0] clr_ff, clr_in;
   logic [31:0] sum_ff, sum_in, div_ff, div_in;
   logic        key_we, rate_we, rate_clr;
   logic [31:0] rate_wdata;
   logic [EW-1:0] ent;
   logic [EW-1:0] scan;

   // bucket memory
   logic        b_we;
   logic [AW-1:0] b_waddr, b_raddr;
   logic [31:0] b_wdata, b_rdata;
   kwrm_ram #(.WIDTH(32), .DEPTH(DEPTH_P)) u_bucket (
      .clock(clock), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(b_wdata),
      .rd_addr(b_raddr), .rd_data(b_rdata)
   );

   div_req_type div_req;
   div_rsp_type div_rsp;
   kwrm_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   function automatic logic [AW-1:0] baddr(input logic [EW-1:0] e, input logic [WW:0] w);
      logic [AW+EW+WW:0] a;
      a = (AW+EW+WW+1)'(e) * (AW+EW+WW+1)'(WINDOW) + (AW+EW+WW+1)'(w);
      return a[AW-1:0];
   endfunction

   assign ent  = hit_idx_ff;
   assign scan = idx_ff[EW-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      valid_in     = valid_ff;
      active_in    = active_ff;
      idle_t_in    = idle_t_ff;
      per_t_in     = per_t_ff;
      trk_t_in     = trk_t_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      w_in         = w_ff;
      clr_in       = clr_ff;
      sum_in       = sum_ff;
      div_in       = div_ff;
      key_we       = 1'b0;
      rate_we      = 1'b0;
      rate_clr     = 1'b0;
      rate_wdata   = '0;
      b_we         = 1'b0;
      b_waddr      = baddr(ent, '0);
      b_wdata      = '0;
      b_raddr      = baddr(ent, '0);
      div_req      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req_data;
               rsp_in     = '0;
               idx_in     = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               if (req_data.command == CMD_TICK) begin
                  if (active_ff) begin
                     idle_t_in = sat_add(idle_t_ff, {16'd0, req_data.elapsed_ms});
                     per_t_in  = sat_add(per_t_ff, {16'd0, req_data.elapsed_ms});
                     trk_t_in  = sat_add(trk_t_ff, {16'd0, req_data.elapsed_ms});
                     state_in  = ST_CLEAR;
                     clr_in    = '0;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else if (req_data.command == CMD_ADD
                            || req_data.command == CMD_QUERY) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SEARCH: begin
            if (valid_ff[scan] && key_ff[scan] == req_ff.key && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = scan;
            end
            if (!valid_ff[scan] && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = scan;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (EW+1)'(ENTRIES - 1)) begin
               state_in = (req_ff.command == CMD_ADD) ? ST_ADD_RD : ST_DONE;
            end
         end
         ST_ADD_RD: begin
            active_in = 1'b1;
            idle_t_in = '0;
            if (hit_ff) begin
               b_raddr      = baddr(ent, '0);
               rsp_in.found = 1'b1;
               state_in     = ST_ADD_WR;
            end else if (free_ok_ff) begin
               hit_idx_in   = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               key_we       = 1'b1;
               rate_clr     = 1'b1;
               rsp_in.found = 1'b1;
               w_in         = '0;
               state_in     = ST_ADD_WR;
            end else begin
               rsp_in.dropped = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_ADD_WR: begin
            b_we    = 1'b1;
            if (hit_ff) begin
               b_waddr  = baddr(ent, '0);
               b_wdata  = sat_add(b_rdata, req_ff.amount);
               state_in = ST_DONE;
            end else begin
               // zero the new entry's window, newest slot gets the amount
               b_waddr = baddr(ent, w_ff);
               b_wdata = (w_ff == '0) ? req_ff.amount : '0;
               w_in    = w_ff + 1'b1;
               if (w_ff == (WW+1)'(WINDOW - 1)) state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            if (idle_t_ff >= idle_limit_ff) begin
               b_we    = 1'b1;
               b_waddr = clr_ff[AW-1:0];
               clr_in  = clr_ff + 1'b1;
               if (clr_ff == (AW+1)'(DEPTH - 1)) begin
                  rate_clr  = 1'b1;
                  active_in = 1'b0;
                  idle_t_in = '0;
                  per_t_in  = '0;
                  trk_t_in  = '0;
                  state_in  = ST_DONE;
               end
            end else if (per_t_ff >= period_ff) begin
               per_t_in   = per_t_ff - period_ff;
               idx_in     = '0;
               hit_idx_in = '0;
               // divisor clamp
               div_in = (trk_t_ff < max_track_ff) ? trk_t_ff : max_track_ff;
               if (div_in < MS_PER_SEC) div_in = MS_PER_SEC;
               state_in = ST_SUM_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SUM_RD: begin
            if (!valid_ff[ent]) begin
               hit_idx_in = ent + 1'b1;
               idx_in     = idx_ff + 1'b1;
               if (idx_ff == (EW+1)'(ENTRIES - 1)) state_in = ST_DONE;
            end else begin
               w_in     = '0;
               sum_in   = '0;
               b_raddr  = baddr(ent, '0);
               state_in = ST_SUM_ACC;
            end
         end
         ST_SUM_ACC: begin
            sum_in  = sat_add(sum_ff, b_rdata);
            w_in    = w_ff + 1'b1;
            b_raddr = baddr(ent, w_ff + 1'b1);
            if (w_ff == (WW+1)'(WINDOW - 1)) state_in = ST_DIV;
         end
         ST_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = {32'd0, sum_ff} * 64'd1000;
            div_req.divisor  = div_ff;
            state_in         = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               rate_we    = 1'b1;
               rate_wdata = div_rsp.quotient;
               w_in       = (WW+1)'(WINDOW - 1);
               state_in   = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (w_ff == '0) begin
               b_we     = 1'b1;
               b_waddr  = baddr(ent, '0);
               hit_idx_in = ent + 1'b1;
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff == (EW+1)'(ENTRIES - 1)) ? ST_DONE : ST_SUM_RD;
            end else begin
               b_raddr  = baddr(ent, w_ff - 1'b1);
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            b_we     = 1'b1;
            b_waddr  = baddr(ent, w_ff);
            b_wdata  = b_rdata;
            w_in     = w_ff - 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_DONE: begin
            if (req_ff.command == CMD_QUERY && hit_ff) begin
               rsp_in.rate  = rate_ff[ent];
               rsp_in.found = 1'b1;
            end
            rsp_in.active = active_ff;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         active_ff    <= 1'b0;
         idle_t_ff    <= '0;
         per_t_ff     <= '0;
         trk_t_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         active_ff    <= active_in;
         idle_t_ff    <= idle_t_in;
         per_t_ff     <= per_t_in;
         trk_t_ff     <= trk_t_in;
      end
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      w_ff        <= w_in;
      clr_ff      <= clr_in;
      sum_ff      <= sum_in;
      div_ff      <= div_in;
   end

   // key and rate tables; rates reset to zero
   always_ff @(posedge clock) begin
      if (key_we) key_ff[free_idx_ff] <= req_ff.key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) rate_ff[i] <= '0;
      end else if (rate_clr && state_ff == ST_CLEAR) begin
         for (int i = 0; i < ENTRIES; i++) rate_ff[i] <= '0;
      end else if (rate_clr) begin
         rate_ff[free_idx_ff] <= '0;
      end else if (rate_we) begin
         rate_ff[ent] <= rate_wdata;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
